// ----- design/sv39_pkg.sv -----
// ----------------------------------------------------------------------------
// Sv39 page table engine package
// Shared types, constants and codes for the page table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sv39_pkg;

  localparam int unsigned PoolPagesDef = 64;
  localparam int unsigned LevelsDef    = 3;
  localparam int unsigned MaxRunDef    = 64;

  localparam int unsigned PpnW    = 44;
  localparam int unsigned VpnW    = 27;
  localparam int unsigned FlagW   = 10;
  localparam int unsigned PteW    = 54;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IdxW    = 9;

  localparam logic [FlagW-1:0] PTE_V = 10'h001;
  localparam logic [FlagW-1:0] PTE_U = 10'h010;
  localparam logic [FlagW-1:0] PTE_A = 10'h040;
  localparam logic [FlagW-1:0] PTE_D = 10'h080;

  localparam logic [VpnW-1:0] VpnMax = '1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_MAP    = 2'd1,
    OP_UNMAP  = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NO_TABLE  = 3'd1,
    ST_NOT_VALID = 3'd2,
    ST_NOT_USER  = 3'd3,
    ST_POOL_FULL = 3'd4,
    ST_REMAPPED  = 3'd5,
    ST_NOT_LEAF  = 3'd6,
    ST_RANGE     = 3'd7
  } status_e;

  localparam logic CfgBase  = 1'b0;
  localparam logic CfgFlags = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD,
    S_EVAL,
    S_ALLOC_CLR,
    S_LINK,
    S_LEAF_RD,
    S_LEAF_EVAL,
    S_EMIT,
    S_WAIT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic    load;       // capture input transaction
    logic    clr_start;  // start sweep from a page
    logic    clr_step;   // write zero at sweep address
    logic    rd_walk;    // read entry at walk level
    logic    rd_leaf;    // read leaf entry
    logic    follow;     // descend into pointed page
    logic    alloc;      // take a new page
    logic    link;       // write pointer to new page
    logic    leaf_wr;    // write leaf (map) or zero (unmap)
    logic    res_set;    // capture result
    status_e res_status;
    logic    res_ok;     // result carries page
    logic    res_last;
    logic    next_page;  // advance run
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    op_e     op;
    logic    params_bad;
    logic    range_bad;
    logic    level_zero;
    logic    entry_valid;
    logic    ptr_bad;
    logic    pool_full;
    logic    clr_done;
    logic    sweep_done;
    logic    leaf_valid;
    logic    leaf_user;
    logic    leaf_is_ptr;
    logic    run_last;
  } stat_t;

endpackage

`default_nettype wire

// ----- design/sv39_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sv39 page table engine controller
// Sequences the walk, allocation, clearing and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sv39_ctrl
  import sv39_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output ctrl_t      ctrl_o,
  input  wire stat_t stat_i
);

  state_e state_q, state_d;
  logic   last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    unique case (state_q)
      S_CLEAR:     if (stat_i.sweep_done) state_d = S_IDLE;
      S_IDLE:      if (in_valid) state_d = S_CHECK;
      S_CHECK: begin
        if (stat_i.op == OP_LOOKUP) state_d = S_RD;
        else if (stat_i.params_bad || stat_i.range_bad) begin
          state_d = S_EMIT;
          last_d  = 1'b1;
        end else state_d = S_RD;
      end
      S_RD:        state_d = stat_i.level_zero ? S_LEAF_RD : S_EVAL;
      S_EVAL: begin
        if (stat_i.entry_valid) begin
          if (stat_i.ptr_bad) begin
            state_d = S_EMIT;
            last_d  = 1'b1;
          end else state_d = S_RD;
        end else if (stat_i.op != OP_MAP || stat_i.pool_full) begin
          state_d = S_EMIT;
          last_d  = 1'b1;
        end else state_d = S_ALLOC_CLR;
      end
      S_ALLOC_CLR: if (stat_i.clr_done) state_d = S_LINK;
      S_LINK:      state_d = S_RD;
      S_LEAF_RD:   state_d = S_LEAF_EVAL;
      S_LEAF_EVAL: begin
        state_d = S_EMIT;
        unique case (stat_i.op)
          OP_MAP:   last_d = stat_i.leaf_valid || stat_i.run_last;
          OP_UNMAP: last_d = !stat_i.leaf_valid || stat_i.leaf_is_ptr || stat_i.run_last;
          default:  last_d = 1'b1;
        endcase
      end
      S_EMIT:      state_d = S_WAIT;
      S_WAIT: begin
        if (out_ready) state_d = last_q ? S_IDLE : S_CHECK;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl_o            = '0;
    ctrl_o.res_status = ST_OK;
    in_ready          = 1'b0;
    out_valid         = 1'b0;
    unique case (state_q)
      S_CLEAR: ctrl_o.clr_step = 1'b1;
      S_IDLE: begin
        in_ready    = 1'b1;
        ctrl_o.load = in_valid;
      end
      S_CHECK: begin
        if (stat_i.op != OP_LOOKUP && (stat_i.params_bad || stat_i.range_bad)) begin
          ctrl_o.res_set    = 1'b1;
          ctrl_o.res_status = ST_RANGE;
          ctrl_o.res_last   = 1'b1;
        end
      end
      S_RD: begin
        ctrl_o.rd_walk = !stat_i.level_zero;
        ctrl_o.rd_leaf = stat_i.level_zero;
      end
      S_EVAL: begin
        if (stat_i.entry_valid) begin
          if (stat_i.ptr_bad) begin
            ctrl_o.res_set    = 1'b1;
            ctrl_o.res_status = ST_RANGE;
            ctrl_o.res_last   = 1'b1;
          end else ctrl_o.follow = 1'b1;
        end else if (stat_i.op != OP_MAP) begin
          ctrl_o.res_set    = 1'b1;
          ctrl_o.res_status = ST_NO_TABLE;
          ctrl_o.res_last   = 1'b1;
        end else if (stat_i.pool_full) begin
          ctrl_o.res_set    = 1'b1;
          ctrl_o.res_status = ST_POOL_FULL;
          ctrl_o.res_last   = 1'b1;
        end else begin
          ctrl_o.alloc     = 1'b1;
          ctrl_o.clr_start = 1'b1;
        end
      end
      S_ALLOC_CLR: ctrl_o.clr_step = 1'b1;
      S_LINK:      ctrl_o.link = 1'b1;
      S_LEAF_RD:   ctrl_o.rd_leaf = 1'b1;
      S_LEAF_EVAL: begin
        ctrl_o.res_set  = 1'b1;
        ctrl_o.res_last = 1'b1;
        unique case (stat_i.op)
          OP_MAP: begin
            if (stat_i.leaf_valid) ctrl_o.res_status = ST_REMAPPED;
            else begin
              ctrl_o.leaf_wr  = 1'b1;
              ctrl_o.res_last = stat_i.run_last;
            end
          end
          OP_UNMAP: begin
            if (!stat_i.leaf_valid) ctrl_o.res_status = ST_NOT_VALID;
            else if (stat_i.leaf_is_ptr) ctrl_o.res_status = ST_NOT_LEAF;
            else begin
              ctrl_o.leaf_wr  = 1'b1;
              ctrl_o.res_ok   = 1'b1;
              ctrl_o.res_last = stat_i.run_last;
            end
          end
          default: begin
            if (!stat_i.leaf_valid) ctrl_o.res_status = ST_NOT_VALID;
            else if (!stat_i.leaf_user) ctrl_o.res_status = ST_NOT_USER;
            else ctrl_o.res_ok = 1'b1;
          end
        endcase
      end
      S_EMIT: ;
      S_WAIT: begin
        out_valid        = 1'b1;
        ctrl_o.next_page = out_ready && !last_q;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/sv39_dpath.sv -----
// ----------------------------------------------------------------------------
// Sv39 page table engine datapath
// Table store, walk registers, allocator, clear sweep and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sv39_dpath
  import sv39_pkg::*;
#(
  parameter int unsigned POOL_PAGES = PoolPagesDef,
  parameter int unsigned LEVELS     = LevelsDef,
  parameter int unsigned MAX_RUN    = MaxRunDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [PpnW-1:0]    cfg_data,
  input  wire logic [1:0]         operation_i,
  input  wire logic [VpnW-1:0]    virt_page_i,
  input  wire logic [PpnW-1:0]    phys_page_i,
  input  wire logic [FlagW-1:0]   permission_bits_i,
  input  wire logic [CountW-1:0]  page_count_i,
  input  wire logic               release_data_i,
  input  wire ctrl_t              ctrl_i,
  output stat_t                   stat_o,
  output logic [StatusW-1:0]      status_o,
  output logic [PpnW-1:0]         result_page_o,
  output logic                    free_request_o,
  output logic                    last_o
);

  localparam int unsigned PgW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned AddrW  = PgW + IdxW;
  localparam int unsigned Depth  = POOL_PAGES * 512;
  localparam int unsigned LvlW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned UsedW  = $clog2(POOL_PAGES + 1);
  localparam logic [LvlW-1:0] TopLvl = LvlW'(LEVELS - 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic [PteW-1:0] mem_q [Depth];
  logic [PteW-1:0] rdata_q;

  logic [PpnW-1:0]   base_q;
  logic [FlagW-1:0]  iflags_q;
  op_e               op_q;
  logic [VpnW-1:0]   vpn_q;
  logic [PpnW-1:0]   ppn_q;
  logic [FlagW-1:0]  perm_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] k_q;
  logic              rel_q;
  logic              vwrap_q;
  logic              pwrap_q;
  logic [LvlW-1:0]   lvl_q;
  logic [PgW-1:0]    page_q;
  logic [UsedW-1:0]  used_q;
  logic [AddrW-1:0]  clr_addr_q;
  logic [IdxW-1:0]   clr_cnt_q;
  logic [PgW-1:0]    new_pg_q;
  logic [StatusW-1:0] st_q;
  logic [PpnW-1:0]   pg_q;
  logic              fr_q;
  logic              last_q;

  logic [IdxW-1:0]   lvl_idx;
  logic [PpnW-1:0]   off;
  logic [AddrW-1:0]  walk_addr;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [PteW-1:0]   wdata;
  logic              rd;
  logic [LvlW-1:0]   lvl_next;

  always_comb begin
    lvl_idx = '0;
    for (int l = 1; l < LEVELS; l++) begin
      if (lvl_q == LvlW'(l)) lvl_idx = vpn_q[9*l +: IdxW];
    end
  end

  assign lvl_next  = lvl_q - LvlW'(1);
  assign walk_addr = {page_q, (lvl_q == '0) ? vpn_q[IdxW-1:0] : lvl_idx};
  assign off       = rdata_q[PteW-1:FlagW] - base_q;

  // Single write port.
  always_comb begin
    we    = 1'b0;
    waddr = walk_addr;
    wdata = '0;
    if (ctrl_i.clr_step) begin
      we    = 1'b1;
      waddr = clr_addr_q;
    end else if (ctrl_i.link) begin
      we    = 1'b1;
      wdata = {base_q + PpnW'(new_pg_q), iflags_q | PTE_V};
    end else if (ctrl_i.leaf_wr) begin
      we = 1'b1;
      if (op_q == OP_MAP) wdata = {ppn_q, perm_q | PTE_V | PTE_A | PTE_D};
    end
  end

  assign rd = ctrl_i.rd_walk || ctrl_i.rd_leaf;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (rd) rdata_q <= mem_q[walk_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      iflags_q   <= '0;
      used_q     <= UsedW'(1);
      clr_addr_q <= '0;
      clr_cnt_q  <= '0;
      new_pg_q   <= '0;
      op_q       <= OP_LOOKUP;
      vpn_q      <= '0;
      ppn_q      <= '0;
      perm_q     <= '0;
      count_q    <= '0;
      rel_q      <= 1'b0;
      k_q        <= '0;
      lvl_q      <= '0;
      page_q     <= '0;
      vwrap_q    <= 1'b0;
      pwrap_q    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgBase) base_q <= cfg_data;
        else iflags_q <= cfg_data[FlagW-1:0];
      end
      if (ctrl_i.clr_start) begin
        clr_addr_q <= {used_q[PgW-1:0], {IdxW{1'b0}}};
        clr_cnt_q  <= '0;
      end else if (ctrl_i.clr_step) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
        clr_cnt_q  <= clr_cnt_q + IdxW'(1);
      end
      if (ctrl_i.alloc) begin
        new_pg_q <= used_q[PgW-1:0];
        used_q   <= used_q + UsedW'(1);
      end
      if (ctrl_i.load) begin
        op_q    <= op_e'(operation_i);
        vpn_q   <= virt_page_i;
        ppn_q   <= phys_page_i;
        perm_q  <= permission_bits_i;
        count_q <= page_count_i;
        rel_q   <= release_data_i;
        k_q     <= '0;
        vwrap_q <= 1'b0;
        pwrap_q <= 1'b0;
        lvl_q   <= TopLvl;
        page_q  <= '0;
      end else if (ctrl_i.next_page) begin
        {vwrap_q, vpn_q} <= {vwrap_q, vpn_q} + (VpnW+1)'(1);
        {pwrap_q, ppn_q} <= {pwrap_q, ppn_q} + (PpnW+1)'(1);
        k_q    <= k_q + CountW'(1);
        lvl_q  <= TopLvl;
        page_q <= '0;
      end else if (ctrl_i.follow) begin
        page_q <= off[PgW-1:0];
        lvl_q  <= lvl_next;
      end else if (ctrl_i.link) begin
        page_q <= new_pg_q;
        lvl_q  <= lvl_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      pg_q   <= '0;
      fr_q   <= 1'b0;
      last_q <= 1'b0;
    end else if (ctrl_i.res_set) begin
      st_q   <= ctrl_i.res_status;
      pg_q   <= ctrl_i.res_ok ? rdata_q[PteW-1:FlagW] : '0;
      fr_q   <= ctrl_i.res_ok && op_q == OP_UNMAP && rel_q;
      last_q <= ctrl_i.res_last;
    end
  end

  always_comb begin
    stat_o             = '0;
    stat_o.op          = op_q;
    stat_o.params_bad  = op_q == OP_BAD || count_q == '0 ||
                         count_q > CountW'(MAX_RUN);
    stat_o.range_bad   = vwrap_q || (op_q == OP_MAP && pwrap_q);
    stat_o.level_zero  = lvl_q == '0;
    stat_o.entry_valid = rdata_q[0];
    stat_o.ptr_bad     = off >= PpnW'(POOL_PAGES);
    stat_o.pool_full   = used_q >= UsedW'(POOL_PAGES);
    stat_o.clr_done    = clr_cnt_q == '1;
    stat_o.sweep_done  = clr_addr_q == LastAddr;
    stat_o.leaf_valid  = rdata_q[0];
    stat_o.leaf_user   = (rdata_q[FlagW-1:0] & PTE_U) != '0;
    stat_o.leaf_is_ptr = rdata_q[FlagW-1:0] == PTE_V;
    stat_o.run_last    = k_q + CountW'(1) == count_q;
  end

  assign status_o       = st_q;
  assign result_page_o  = pg_q;
  assign free_request_o = fr_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

// ----- design/sv39_page_table_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Sv39 page table engine
// Keeps a multi-level Sv39 page table in a private pool of table pages.
// ----------------------------------------------------------------------------
// An input transaction carries a lookup, a map run or an unmap run. It is
// taken on in_valid and in_ready and produces one result transaction per
// processed page on out_valid and out_ready; the final one has last set.
// One transaction is worked on at a time. A page takes a check, a read and
// an evaluate per upper table level, a read, a second read and an evaluate
// for the leaf that registers the result, and an emit state before the
// result is presented; the first page also waits for the accept in idle.
// Each table page allocated during a map adds a clear of 512 entries, one
// per cycle on the single memory write port, and the link.
// After reset the whole pool is swept clear, one entry per cycle, before the
// first input is taken; configuration writes are accepted meanwhile.
// While the receiver stalls the result is held and no further work starts.
// Configuration is written with cfg_we_i, cfg_index_i and cfg_data_i.
// ----------------------------------------------------------------------------
`default_nettype none

module sv39_page_table_engine_unit
  import sv39_pkg::*;
#(
  parameter int unsigned POOL_PAGES = PoolPagesDef,
  parameter int unsigned LEVELS     = LevelsDef,
  parameter int unsigned MAX_RUN    = MaxRunDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [PpnW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [VpnW-1:0]    virt_page_i,
  input  wire logic [PpnW-1:0]    phys_page_i,
  input  wire logic [FlagW-1:0]   permission_bits_i,
  input  wire logic [CountW-1:0]  page_count_i,
  input  wire logic               release_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [StatusW-1:0]      status_o,
  output logic [PpnW-1:0]         result_page_o,
  output logic                    free_request_o,
  output logic                    last_o
);

  ctrl_t ctrl;
  stat_t stat;

  sv39_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid_i),
    .in_ready  (in_ready_o),
    .out_valid (out_valid_o),
    .out_ready (out_ready_i),
    .ctrl_o    (ctrl),
    .stat_i    (stat)
  );

  sv39_dpath #(
    .POOL_PAGES (POOL_PAGES),
    .LEVELS     (LEVELS),
    .MAX_RUN    (MAX_RUN)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we            (cfg_we_i),
    .cfg_index         (cfg_index_i),
    .cfg_data          (cfg_data_i),
    .operation_i       (operation_i),
    .virt_page_i       (virt_page_i),
    .phys_page_i       (phys_page_i),
    .permission_bits_i (permission_bits_i),
    .page_count_i      (page_count_i),
    .release_data_i    (release_data_i),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .status_o          (status_o),
    .result_page_o     (result_page_o),
    .free_request_o    (free_request_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

// ----- design/sv39_checker.sv -----
// ----------------------------------------------------------------------------
// Sv39 page table engine checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sv39_checker
  import sv39_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [StatusW-1:0] status_o,
  input wire logic [PpnW-1:0]    result_page_o,
  input wire logic               free_request_o,
  input wire logic               last_o
);

  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while a result is pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_page_o) &&
    $stable(status_o) && $stable(last_o)) else $error("result changed under stall");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o) else $error("error without last");

  a_err_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> result_page_o == '0 && !free_request_o)
    else $error("error result carries a page");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second accept too soon");

endmodule

bind sv39_page_table_engine_unit sv39_checker u_sv39_checker (.*);

`default_nettype wire
